[sv/smp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_SHORT          = 3'd1;
  localparam logic [2:0] ST_TRUNC          = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_ATTR   = 3'd3;
  localparam logic [2:0] ST_MALFORMED      = 3'd4;
  localparam logic [2:0] ST_UNKNOWN_FAMILY = 3'd5;

  localparam logic [31:0] COOKIE          = 32'h2112_A442;
  localparam logic [11:0] ATTR_MAPPED     = 12'h000;
  localparam logic [11:0] ATTR_XOR_MAPPED = 12'h020;
  localparam logic [15:0] FAMILY_IPV4     = 16'd1;
  localparam logic [15:0] FAMILY_IPV6     = 16'd2;
  localparam logic [15:0] LEN_IPV4        = 16'd8;
  localparam logic [15:0] LEN_IPV6        = 16'd20;

  localparam int HEADER_BYTES = 20;
  localparam int VALUE_BYTES  = 20;

  typedef logic [VALUE_BYTES-1:0][7:0] smp_vbytes_t;
  typedef logic [2:0][31:0] smp_txn_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } smp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] message_kind;
    logic        found;
    logic        is_ipv6;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] txn_high;
    logic [63:0] txn_low;
  } smp_out_t;

  typedef struct packed {
    logic [2:0]  err;
    logic        is_ipv6;
    logic [15:0] port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } smp_addr_t;

endpackage

`default_nettype wire

[sv/smp_addr_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module smp_addr_decode import smp_pkg::*; (
  input  wire smp_vbytes_t  vbytes,
  input  wire logic [11:0]  attr_code,
  input  wire logic [15:0]  attr_len,
  input  wire smp_txn_t     txn,
  output smp_addr_t         addr
);

  logic [15:0] family;
  logic        xr;
  logic [63:0] v4_raw;
  logic [63:0] hi_raw;
  logic [63:0] lo_raw;

  assign family = {vbytes[0], vbytes[1]};
  assign xr     = (attr_code == ATTR_XOR_MAPPED);
  assign v4_raw = {32'd0, vbytes[4], vbytes[5], vbytes[6], vbytes[7]};
  assign hi_raw = {vbytes[4], vbytes[5], vbytes[6], vbytes[7],
                   vbytes[8], vbytes[9], vbytes[10], vbytes[11]};
  assign lo_raw = {vbytes[12], vbytes[13], vbytes[14], vbytes[15],
                   vbytes[16], vbytes[17], vbytes[18], vbytes[19]};

  always_comb begin
    addr.err       = ST_OK;
    addr.is_ipv6   = (family == FAMILY_IPV6);
    addr.port      = {vbytes[2], vbytes[3]} ^ (xr ? COOKIE[31:16] : 16'd0);
    addr.addr_high = 64'd0;
    addr.addr_low  = 64'd0;
    if (attr_len < 16'd2) begin
      addr.err = ST_MALFORMED;
    end else if (family != FAMILY_IPV4 && family != FAMILY_IPV6) begin
      addr.err = ST_UNKNOWN_FAMILY;
    end else if ((family == FAMILY_IPV4 && attr_len != LEN_IPV4) ||
                 (family == FAMILY_IPV6 && attr_len != LEN_IPV6)) begin
      addr.err = ST_MALFORMED;
    end
    if (family == FAMILY_IPV6) begin
      addr.addr_high = hi_raw ^ (xr ? {COOKIE, txn[0]} : 64'd0);
      addr.addr_low  = lo_raw ^ (xr ? {txn[1], txn[2]} : 64'd0);
    end else begin
      addr.addr_low  = v4_raw ^ (xr ? {32'd0, COOKIE} : 64'd0);
    end
  end

endmodule

`default_nettype wire

[sv/stun_message_parser.sv]
// stun message parser
// in channel: one message byte per word (in_data.data_byte) with in_data.last on
// the final byte of the datagram; in_valid / in_stall handshake
// out channel: one result word per datagram (status, message type, transaction
// id, first mapped address), issued after the word carrying last
// a byte is held in an input register, then decoded into the parse state
// and, on the last byte, into the output register
// the result shows on out_valid once the last byte, held in the input register,
// has been decoded into the output register; throughput is one byte per clock
// except here: a byte without last always moves on; a last byte waits in
// the input register while an older result is stalled, and in_stall then rises
// reset (rst_n low, synchronous) clears the parse state and both valid flags;
// after each result the parse state returns to its reset values
`timescale 1ns / 1ps
`default_nettype none

module stun_message_parser import smp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire smp_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output smp_out_t     out_data
);

  logic        s1_valid_r, s1_valid_nxt;
  smp_in_t     s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  smp_out_t    out_data_r, out_data_nxt;

  logic [16:0] bp_r, bp_nxt;
  logic [15:0] ht_r, ht_nxt;
  logic [15:0] bl_r, bl_nxt;
  smp_txn_t    txn_r, txn_nxt;
  logic [15:0] ph_r, ph_nxt;
  logic [11:0] code_r, code_nxt;
  logic [15:0] alen_r, alen_nxt;
  smp_vbytes_t vb_r, vb_nxt;
  logic        found_r, found_nxt;
  logic        fam6_r, fam6_nxt;
  logic [15:0] port_r, port_nxt;
  logic [63:0] ahi_r, ahi_nxt;
  logic [63:0] alo_r, alo_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        in_accept;
  logic        s1_adv;
  logic        out_blocked;
  logic [7:0]  b;
  logic [16:0] msg_end;
  logic [16:0] msg_end_nxt;
  logic [15:0] vk;
  logic [4:0]  hdr_off;
  logic [1:0]  tw;
  logic        fin_go;
  logic [2:0]  status;
  smp_addr_t   fin;

  assign out_blocked = out_valid_r & out_stall;
  assign s1_adv      = s1_valid_r & (~s1_data_r.last | ~out_blocked);
  assign in_stall    = s1_valid_r & ~s1_adv;
  assign in_accept   = in_valid & ~in_stall;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  assign b       = s1_data_r.data_byte;
  assign msg_end = {1'b0, bl_r} + 17'(HEADER_BYTES);
  assign vk      = ph_r - 16'd4;
  assign hdr_off = bp_r[4:0] - 5'd8;
  assign tw      = hdr_off[3:2];

  // value bytes of the current attribute, with this word written in
  always_comb begin
    vb_nxt = vb_r;
    if (ph_r >= 16'd4 && vk < 16'(VALUE_BYTES)) begin
      vb_nxt[vk[4:0]] = b;
    end
  end

  smp_addr_decode u_decode (
    .vbytes    (vb_nxt),
    .attr_code (code_r),
    .attr_len  (alen_r),
    .txn       (txn_r),
    .addr      (fin)
  );

  always_comb begin
    bp_nxt    = bp_r;
    ht_nxt    = ht_r;
    bl_nxt    = bl_r;
    txn_nxt   = txn_r;
    ph_nxt    = ph_r;
    code_nxt  = code_r;
    alen_nxt  = alen_r;
    found_nxt = found_r;
    fam6_nxt  = fam6_r;
    port_nxt  = port_r;
    ahi_nxt   = ahi_r;
    alo_nxt   = alo_r;
    err_nxt   = err_r;
    fin_go    = 1'b0;
    if (!bp_r[16]) begin
      bp_nxt = bp_r + 17'd1;
      if (err_r == ST_OK) begin
        if (bp_r < 17'(HEADER_BYTES)) begin
          priority if (bp_r < 17'd2) begin
            ht_nxt = {ht_r[7:0], b};
          end else if (bp_r < 17'd4) begin
            bl_nxt = {bl_r[7:0], b};
          end else if (bp_r >= 17'd8) begin
            txn_nxt[tw] = {txn_r[tw][23:0], b};
          end else begin
            // cookie bytes, not checked
          end
        end else if (!(ph_r == 16'd0 && bp_r >= msg_end)) begin
          ph_nxt = ph_r + 16'd1;
          priority if (ph_r == 16'd0) begin
            code_nxt = {b[3:0], 8'h00};
          end else if (ph_r == 16'd1) begin
            code_nxt = {code_r[11:8], b};
          end else if (ph_r == 16'd2) begin
            alen_nxt = {b, 8'h00};
          end else if (ph_r == 16'd3) begin
            alen_nxt = {alen_r[15:8], b};
            priority if (({1'b0, bp_r} + 18'd1 + {2'b00, alen_nxt}) >
                         {1'b0, msg_end}) begin
              err_nxt = ST_TRUNC;
            end else if (code_r != ATTR_MAPPED && code_r != ATTR_XOR_MAPPED) begin
              err_nxt = ST_UNKNOWN_ATTR;
            end else if (alen_nxt == 16'd0) begin
              ph_nxt  = 16'd0;
              err_nxt = ST_MALFORMED;
            end else begin
              // value bytes follow
            end
          end else begin
            if (vk + 16'd1 == alen_r) begin
              ph_nxt = 16'd0;
              fin_go = 1'b1;
            end
          end
        end
      end
    end
    if (fin_go) begin
      if (fin.err != ST_OK) begin
        err_nxt = fin.err;
      end else if (!found_r) begin
        found_nxt = 1'b1;
        fam6_nxt  = fin.is_ipv6;
        port_nxt  = fin.port;
        ahi_nxt   = fin.addr_high;
        alo_nxt   = fin.addr_low;
      end
    end
  end

  assign msg_end_nxt = {1'b0, bl_nxt} + 17'(HEADER_BYTES);

  always_comb begin
    priority if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (bp_nxt < 17'(HEADER_BYTES)) begin
      status = ST_SHORT;
    end else if (!(ph_nxt == 16'd0 && bp_nxt >= msg_end_nxt)) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end
    out_data_nxt = '0;
    out_data_nxt.status = status;
    if (status != ST_SHORT) begin
      out_data_nxt.message_kind = ht_nxt;
      out_data_nxt.txn_high     = txn_nxt[0];
      out_data_nxt.txn_low      = {txn_nxt[1], txn_nxt[2]};
    end
    if (status == ST_OK && found_nxt) begin
      out_data_nxt.found     = 1'b1;
      out_data_nxt.is_ipv6   = fam6_nxt;
      out_data_nxt.port      = port_nxt;
      out_data_nxt.addr_high = ahi_nxt;
      out_data_nxt.addr_low  = alo_nxt;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_data_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_data_r.last) begin
      out_data_r <= out_data_nxt;
    end
    if (s1_adv) begin
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // parse state, back to reset values after each datagram
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_adv && s1_data_r.last)) begin
      bp_r    <= '0;
      ht_r    <= '0;
      bl_r    <= '0;
      txn_r   <= '0;
      ph_r    <= '0;
      code_r  <= '0;
      alen_r  <= '0;
      found_r <= 1'b0;
      fam6_r  <= 1'b0;
      port_r  <= '0;
      ahi_r   <= '0;
      alo_r   <= '0;
      err_r   <= ST_OK;
    end else if (s1_adv) begin
      bp_r    <= bp_nxt;
      ht_r    <= ht_nxt;
      bl_r    <= bl_nxt;
      txn_r   <= txn_nxt;
      ph_r    <= ph_nxt;
      code_r  <= code_nxt;
      alen_r  <= alen_nxt;
      found_r <= found_nxt;
      fam6_r  <= fam6_nxt;
      port_r  <= port_nxt;
      ahi_r   <= ahi_nxt;
      alo_r   <= alo_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

`default_nettype wire

[verif/stun_message_parser_test.sv]
`timescale 1ns / 1ps

module stun_message_parser_test;
  import smp_pkg::*;

  localparam int unsigned PACKET_LIMIT = 65536;
  localparam logic [15:0] FAMILY_NONE  = 16'd0;
  localparam logic [15:0] FAMILY_BOGUS = 16'd3;
  localparam logic [15:0] ATTR_BOGUS   = 16'h8022;

  typedef enum logic [3:0] {
    SH_SHORT, SH_HDR_ONLY, SH_ONE_ATTR, SH_TWO_ATTR, SH_BAD_SECOND,
    SH_PAST_END, SH_EARLY_END, SH_TRAILING
  } shape_t;

  typedef struct packed {
    shape_t      shape;
    logic [15:0] mtype;
    logic [95:0] txn;
    logic [15:0] atype;
    logic [15:0] fam;
    logic [15:0] vlen;
    logic [7:0]  fill;
    logic [7:0]  count;
    logic        typed;
    logic [2:0]  status;
  } dir_case_t;

  localparam logic [95:0] TXN_A = 96'h0123_4567_89AB_CDEF_FEDC_BA98;
  localparam logic [95:0] TXN_B = 96'h8000_0001_7FFF_FFFE_A5A5_5A5A;
  localparam logic [95:0] TXN_F = {96{1'b1}};

  dir_case_t dir_cases [21] = '{
    '{SH_SHORT, 16'h0000, 96'h0, 16'h0, 16'h0, 16'h0, 8'h00, 8'd1, 1'b1, ST_SHORT},
    '{SH_SHORT, 16'h0000, 96'h0, 16'h0, 16'h0, 16'h0, 8'hFF, 8'd19, 1'b1, ST_SHORT},
    '{SH_HDR_ONLY, 16'h0000, 96'h0, 16'h0, 16'h0, 16'h0, 8'h00, 8'd0, 1'b1, ST_OK},
    '{SH_HDR_ONLY, 16'hFFFF, TXN_F, 16'h0, 16'h0, 16'h0, 8'h00, 8'd0, 1'b1, ST_OK},
    '{SH_ONE_ATTR, 16'h0101, TXN_A, {4'h0, ATTR_MAPPED}, FAMILY_IPV4, LEN_IPV4, 8'hFF,
      8'd0, 1'b0, ST_OK},
    '{SH_ONE_ATTR, 16'h0101, TXN_A, {4'h0, ATTR_XOR_MAPPED}, FAMILY_IPV4, LEN_IPV4, 8'h00,
      8'd0, 1'b0, ST_OK},
    '{SH_ONE_ATTR, 16'h0101, TXN_B, {4'h0, ATTR_MAPPED}, FAMILY_IPV6, LEN_IPV6, 8'hA5,
      8'd0, 1'b0, ST_OK},
    '{SH_ONE_ATTR, 16'h0101, TXN_F, {4'h0, ATTR_XOR_MAPPED}, FAMILY_IPV6, LEN_IPV6, 8'hFF,
      8'd0, 1'b0, ST_OK},
    '{SH_ONE_ATTR, 16'h0111, TXN_A, {4'hF, ATTR_XOR_MAPPED}, FAMILY_IPV4, LEN_IPV4, 8'h5A,
      8'd0, 1'b0, ST_OK},
    '{SH_TWO_ATTR, 16'h0101, TXN_B, {4'h0, ATTR_XOR_MAPPED}, FAMILY_IPV6, LEN_IPV6, 8'h3C,
      8'd0, 1'b0, ST_OK},
    '{SH_ONE_ATTR, 16'h0001, TXN_A, {4'h0, ATTR_MAPPED}, FAMILY_IPV4, 16'd0, 8'h00, 8'd0,
      1'b1, ST_MALFORMED},
    '{SH_ONE_ATTR, 16'h0001, TXN_B, {4'h0, ATTR_XOR_MAPPED}, FAMILY_IPV4, 16'd1, 8'h00,
      8'd0, 1'b1, ST_MALFORMED},
    '{SH_ONE_ATTR, 16'h0101, TXN_A, {4'h0, ATTR_MAPPED}, FAMILY_BOGUS, LEN_IPV4, 8'h11,
      8'd0, 1'b1, ST_UNKNOWN_FAMILY},
    '{SH_ONE_ATTR, 16'h0101, TXN_B, {4'h0, ATTR_XOR_MAPPED}, FAMILY_NONE, LEN_IPV6, 8'h22,
      8'd0, 1'b1, ST_UNKNOWN_FAMILY},
    '{SH_ONE_ATTR, 16'h0101, TXN_A, {4'h0, ATTR_XOR_MAPPED}, FAMILY_IPV4, LEN_IPV6, 8'h33,
      8'd0, 1'b1, ST_MALFORMED},
    '{SH_ONE_ATTR, 16'h0101, TXN_B, {4'h0, ATTR_MAPPED}, FAMILY_IPV6, LEN_IPV4, 8'h44,
      8'd0, 1'b1, ST_MALFORMED},
    '{SH_TWO_ATTR, 16'h0101, TXN_A, ATTR_BOGUS, FAMILY_IPV4, LEN_IPV4, 8'h55, 8'd0,
      1'b1, ST_UNKNOWN_ATTR},
    '{SH_BAD_SECOND, 16'h0101, TXN_B, {4'h0, ATTR_MAPPED}, FAMILY_IPV4, LEN_IPV6, 8'h66,
      8'd0, 1'b1, ST_MALFORMED},
    '{SH_PAST_END, 16'h0101, TXN_A, ATTR_BOGUS, FAMILY_IPV4, LEN_IPV4, 8'h77, 8'd0,
      1'b1, ST_TRUNC},
    '{SH_EARLY_END, 16'h0101, TXN_B, 16'h0, 16'h0, 16'h0, 8'h00, 8'd0, 1'b1, ST_TRUNC},
    '{SH_TRAILING, 16'h0101, TXN_A, {4'h0, ATTR_XOR_MAPPED}, FAMILY_IPV4, LEN_IPV4, 8'hC3,
      8'd3, 1'b0, ST_OK}
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  smp_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  smp_out_t out_data;

  stun_message_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // parser state mirror
  int unsigned pos_cnt;
  int unsigned body_len;
  int unsigned attr_idx;
  int unsigned attr_len;
  logic [15:0] msg_type;
  logic [31:0] txn_w [3];
  logic [11:0] attr_type;
  logic [7:0]  val_buf [VALUE_BYTES];
  bit          have_addr;
  bit          addr_v6;
  logic [15:0] addr_port;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [2:0]  err_code;

  smp_out_t   awaited_reports [$];
  logic [7:0] datagram [$];
  smp_out_t   want;
  bit         failed = 1'b0;

  function automatic void clear_parse();
    pos_cnt   = 0;
    body_len  = 0;
    attr_idx  = 0;
    attr_len  = 0;
    msg_type  = '0;
    attr_type = '0;
    have_addr = 1'b0;
    addr_v6   = 1'b0;
    addr_port = '0;
    addr_hi   = '0;
    addr_lo   = '0;
    err_code  = ST_OK;
    foreach (txn_w[i]) txn_w[i] = '0;
    foreach (val_buf[i]) val_buf[i] = '0;
  endfunction

  function automatic void close_attr();
    logic [15:0] fam;
    logic [15:0] prt;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          xr;
    xr = (attr_type == ATTR_XOR_MAPPED);
    if (attr_len < 2) begin
      err_code = ST_MALFORMED;
      return;
    end
    fam = {val_buf[0], val_buf[1]};
    if (fam != FAMILY_IPV4 && fam != FAMILY_IPV6) begin
      err_code = ST_UNKNOWN_FAMILY;
      return;
    end
    if ((fam == FAMILY_IPV4 && attr_len != LEN_IPV4) ||
        (fam == FAMILY_IPV6 && attr_len != LEN_IPV6)) begin
      err_code = ST_MALFORMED;
      return;
    end
    prt = {val_buf[2], val_buf[3]};
    hi = '0;
    lo = '0;
    if (fam == FAMILY_IPV4) begin
      for (int i = 4; i < 8; i++) lo = {lo[55:0], val_buf[5'(i)]};
      if (xr) lo ^= {32'd0, COOKIE};
    end else begin
      for (int i = 4; i < 12; i++) hi = {hi[55:0], val_buf[5'(i)]};
      for (int i = 12; i < 20; i++) lo = {lo[55:0], val_buf[5'(i)]};
      if (xr) begin
        hi ^= {COOKIE, txn_w[0]};
        lo ^= {txn_w[1], txn_w[2]};
      end
    end
    if (xr) prt ^= COOKIE[31:16];
    if (!have_addr) begin
      have_addr = 1'b1;
      addr_v6   = (fam == FAMILY_IPV6);
      addr_port = prt;
      addr_hi   = hi;
      addr_lo   = lo;
    end
  endfunction

  function automatic bit parse_byte(input smp_in_t w, output smp_out_t rep);
    int unsigned b;
    int unsigned k;
    int unsigned msg_end;
    logic [2:0]  st;
    b = w.data_byte;
    msg_end = body_len + HEADER_BYTES;
    rep = '0;
    if (pos_cnt < PACKET_LIMIT && err_code == ST_OK) begin
      if (pos_cnt < HEADER_BYTES) begin
        if (pos_cnt < 2) msg_type = {msg_type[7:0], w.data_byte};
        else if (pos_cnt < 4) body_len = ((body_len << 8) | b) & 32'hFFFF;
        else if (pos_cnt >= 8)
          txn_w[2'((pos_cnt - 8) / 4)] = {txn_w[2'((pos_cnt - 8) / 4)][23:0], w.data_byte};
      end else if (!(attr_idx == 0 && pos_cnt >= msg_end)) begin
        k = attr_idx;
        attr_idx = (attr_idx + 1) & 32'hFFFF;
        if (k == 0) attr_type = {w.data_byte[3:0], 8'h00};
        else if (k == 1) attr_type[7:0] = w.data_byte;
        else if (k == 2) attr_len = b << 8;
        else if (k == 3) begin
          attr_len |= b;
          if (pos_cnt + 1 + attr_len > msg_end) err_code = ST_TRUNC;
          else if (attr_type != ATTR_MAPPED && attr_type != ATTR_XOR_MAPPED)
            err_code = ST_UNKNOWN_ATTR;
          else if (attr_len == 0) begin
            attr_idx = 0;
            close_attr();
          end
        end else begin
          if (k - 4 < VALUE_BYTES) val_buf[5'(k - 4)] = w.data_byte;
          if (k - 3 == attr_len) begin
            attr_idx = 0;
            close_attr();
          end
        end
      end
    end
    if (pos_cnt < PACKET_LIMIT) pos_cnt++;
    if (!w.last) return 1'b0;

    if (err_code != ST_OK) st = err_code;
    else if (pos_cnt < HEADER_BYTES) st = ST_SHORT;
    else if (!(attr_idx == 0 && pos_cnt >= body_len + HEADER_BYTES)) st = ST_TRUNC;
    else st = ST_OK;
    rep.status = st;
    if (st != ST_SHORT) begin
      rep.message_kind = msg_type;
      rep.txn_high     = txn_w[0];
      rep.txn_low      = {txn_w[1], txn_w[2]};
    end
    if (st == ST_OK && have_addr) begin
      rep.found     = 1'b1;
      rep.is_ipv6   = addr_v6;
      rep.port      = addr_port;
      rep.addr_high = addr_hi;
      rep.addr_low  = addr_lo;
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void append_byte(logic [7:0] v);
    datagram.insert(datagram.size(), v);
  endfunction

  function automatic void push16(logic [15:0] v);
    append_byte(v[15:8]);
    append_byte(v[7:0]);
  endfunction

  function automatic void put_header(logic [15:0] mtype, logic [95:0] txn, bit real_cookie);
    push16(mtype);
    push16(16'h0000);
    for (int i = 3; i >= 0; i--)
      append_byte(real_cookie ? COOKIE[i*8 +: 8] : 8'($urandom));
    for (int i = 11; i >= 0; i--) append_byte(txn[i*8 +: 8]);
  endfunction

  function automatic void put_attr(logic [15:0] atype, int vlen, logic [15:0] fam,
                                   logic [7:0] fill, bit scramble);
    push16(atype);
    push16(16'(vlen));
    for (int i = 0; i < vlen; i++) begin
      if (i == 0) append_byte(fam[15:8]);
      else if (i == 1) append_byte(fam[7:0]);
      else append_byte(scramble ? 8'($urandom) : fill);
    end
  endfunction

  function automatic void seal_body();
    logic [15:0] blen;
    blen = 16'(datagram.size() - HEADER_BYTES);
    datagram[2] = blen[15:8];
    datagram[3] = blen[7:0];
  endfunction

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      failed = 1'b1;
    end
  endfunction

  task automatic send_datagram(input bit typed, input smp_out_t typed_rep, input bit burst);
    smp_in_t  w;
    smp_out_t rep;
    int       gap;
    for (int i = 0; i < datagram.size(); i++) begin
      gap = burst ? 0 : $urandom_range(0, 7);
      w.data_byte = datagram[i];
      w.last      = (i == datagram.size() - 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= w;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (parse_byte(w, rep))
        awaited_reports.insert(awaited_reports.size(), typed ? typed_rep : rep);
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected report word, status %0d", out_data.status);
        failed = 1'b1;
      end else begin
        want = awaited_reports.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("message_kind", 64'(want.message_kind), 64'(out_data.message_kind));
        check_field("found", 64'(want.found), 64'(out_data.found));
        check_field("is_ipv6", 64'(want.is_ipv6), 64'(out_data.is_ipv6));
        check_field("port", 64'(want.port), 64'(out_data.port));
        check_field("addr_high", want.addr_high, out_data.addr_high);
        check_field("addr_low", want.addr_low, out_data.addr_low);
        check_field("txn_high", 64'(want.txn_high), 64'(out_data.txn_high));
        check_field("txn_low", want.txn_low, out_data.txn_low);
      end
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    bit calm;
    calm = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    dir_case_t   c;
    smp_out_t    rep;
    logic [15:0] blen;
    logic [11:0] code;
    logic [3:0]  nib;
    int          r;
    int          pick;
    int          cut;
    int          sent_bytes;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    clear_parse();
    sent_bytes = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_cases[i]) begin
      c = dir_cases[i];
      datagram.delete();
      if (c.shape == SH_SHORT) begin
        repeat (c.count) append_byte(c.fill);
      end else begin
        put_header(c.mtype, c.txn, 1'b1);
        unique case (c.shape)
          SH_ONE_ATTR, SH_PAST_END, SH_TRAILING: begin
            put_attr(c.atype, int'(c.vlen), c.fam, c.fill, 1'b0);
          end
          SH_TWO_ATTR: begin
            put_attr(c.atype, int'(c.vlen), c.fam, c.fill, 1'b0);
            put_attr({4'h0, ATTR_XOR_MAPPED}, int'(LEN_IPV4), FAMILY_IPV4, c.fill, 1'b0);
          end
          SH_BAD_SECOND: begin
            put_attr({4'h0, ATTR_MAPPED}, int'(LEN_IPV4), FAMILY_IPV4, c.fill, 1'b0);
            put_attr(c.atype, int'(c.vlen), c.fam, c.fill, 1'b0);
          end
          default: begin
          end
        endcase
        seal_body();
        if (c.shape == SH_EARLY_END) datagram[3] = 8'd12;
        if (c.shape == SH_PAST_END) begin
          blen = {datagram[2], datagram[3]} - 16'd1;
          datagram[2] = blen[15:8];
          datagram[3] = blen[7:0];
        end
        if (c.shape == SH_TRAILING) repeat (c.count) append_byte(c.fill);
      end
      rep = '0;
      rep.status = c.status;
      if (c.status != ST_SHORT) begin
        rep.message_kind = c.mtype;
        rep.txn_high     = c.txn[95:64];
        rep.txn_low      = c.txn[63:0];
      end
      sent_bytes += datagram.size();
      send_datagram(c.typed, rep, $urandom_range(0, 3) == 0);
    end

    while (sent_bytes < 1250) begin
      datagram.delete();
      r = $urandom_range(0, 99);
      put_header(16'($urandom), {$urandom, $urandom, $urandom}, r < 95);
      repeat ($urandom_range(0, 3)) begin
        pick = $urandom_range(0, 9);
        nib  = 4'($urandom_range(0, 15));
        code = pick[0] ? ATTR_XOR_MAPPED : ATTR_MAPPED;
        if (pick < 4) put_attr({nib, code}, int'(LEN_IPV4), FAMILY_IPV4, 8'h00, 1'b1);
        else if (pick < 8) put_attr({nib, code}, int'(LEN_IPV6), FAMILY_IPV6, 8'h00, 1'b1);
        else if (pick == 8)
          put_attr({nib, code}, int'($urandom_range(0, 24)), 16'($urandom_range(0, 3)),
                   8'h00, 1'b1);
        else put_attr(16'($urandom), int'($urandom_range(0, 12)), 16'($urandom), 8'h00, 1'b1);
      end
      seal_body();
      if (r >= 80 && r < 88) begin
        cut = $urandom_range(1, datagram.size() - 1);
        while (datagram.size() > cut) void'(datagram.pop_back());
      end else if (r >= 88 && r < 94) begin
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
      end else if (r >= 94) begin
        datagram[2] = r[0] ? 8'($urandom) : 8'h00;
        datagram[3] = 8'($urandom);
      end
      sent_bytes += datagram.size();
      send_datagram(1'b0, '0, $urandom_range(0, 3) == 0);
    end

    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed && awaited_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
